// ===== rtl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fit-policy partition allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int REM_W    = 16;
    localparam int POLICY_W = 2;

    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  block_index;
        logic [REM_W-1:0]    remaining;
    } t_result;

endpackage

// ===== rtl/fpa_mem.sv =====
// ----------------------------------------------------------------------------
// fpa_mem
// Block table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpa_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer: appends loads, scans the block table for allocations and
// writes the chosen block back.
// ----------------------------------------------------------------------------
module fpa_ctrl
    import fpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_busy,
    input  logic                i_mode,
    input  logic [15:0]         i_size,
    input  logic [POLICY_W-1:0] i_policy,
    output logic                o_res_vld,
    output t_result             o_res,
    input  logic                i_res_take
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_best, n_best;
    logic [SIZE_BITS-1:0] r_size, n_size;
    t_result              r_res, n_res;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [SIZE_BITS-1:0] mem_rdata;

    logic [31:0]          size_ext;
    logic [SIZE_BITS-1:0] size_eff;
    logic                 accept;
    logic                 fits;
    logic                 better;
    logic                 scan_end;
    logic [SIZE_BITS-1:0] new_rem;

    function automatic t_result make_res(input logic [STATUS_W-1:0] st,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [SIZE_BITS-1:0] rem);
        t_result     res;
        logic [15:0] idx_ext;
        logic [31:0] rem_ext;
        idx_ext         = 16'(idx);
        rem_ext         = 32'(rem);
        res.status      = st;
        res.block_index = idx_ext[INDEX_W-1:0];
        res.remaining   = rem_ext[REM_W-1:0];
        return res;
    endfunction

    fpa_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (SIZE_BITS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    assign size_ext = 32'(i_size);
    assign size_eff = size_ext[SIZE_BITS-1:0];
    assign accept   = (r_state == S_IDLE) && i_valid;
    assign mem_re   = (r_state == S_SCAN) && (r_addr < r_count);
    assign fits     = r_rd_vld && (r_size <= mem_rdata);
    assign scan_end = (r_state == S_SCAN) && !r_rd_vld && (r_addr == r_count);
    assign new_rem  = r_best - r_size;

    always_comb begin
        case (i_policy)
            POL_BEST:  better = mem_rdata < r_best;
            POL_WORST: better = mem_rdata > r_best;
            default:   better = 1'b0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_rd_vld  = mem_re;
        n_rd_idx  = r_addr[IDX_W-1:0];
        n_found   = r_found;
        n_pick    = r_pick;
        n_best    = r_best;
        n_size    = r_size;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_pick;
        mem_wdata = new_rem;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_size  = size_eff;
                    n_addr  = '0;
                    n_found = 1'b0;
                    if (i_mode) begin
                        n_state = S_SCAN;
                    end else if (r_count == CNT_W'(MAX_BLOCKS)) begin
                        n_res   = make_res(ST_FULL, '0, '0);
                        n_state = S_DONE;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[IDX_W-1:0];
                        mem_wdata = size_eff;
                        n_count   = r_count + 1'b1;
                        n_res     = make_res(ST_LOADED, r_count[IDX_W-1:0], size_eff);
                        n_state   = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (mem_re) begin
                    n_addr = r_addr + 1'b1;
                end
                if (fits && (!r_found || better)) begin
                    n_found = 1'b1;
                    n_pick  = r_rd_idx;
                    n_best  = mem_rdata;
                end
                if (scan_end) begin
                    if (r_found) begin
                        mem_we = 1'b1;
                        n_res  = make_res(ST_ALLOC, r_pick, new_rem);
                    end else begin
                        n_res  = make_res(ST_NOFIT, '0, '0);
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
        r_addr   <= n_addr;
        r_rd_idx <= n_rd_idx;
        r_found  <= n_found;
        r_pick   <= n_pick;
        r_best   <= n_best;
        r_size   <= n_size;
        r_res    <= n_res;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_res_vld = (r_state == S_DONE);
    assign o_res     = r_res;

endmodule

// ===== rtl/fit_policy_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator
// Free block table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
//  channel   | valid    | stall    | payload
//  ----------+----------+----------+-------------------------------------
//  input     | i_valid  | o_stall  | i_mode, i_size
//  result    | o_valid  | i_stall  | o_status, o_block_index, o_remaining
//  config    | i_cfg_we | -        | i_cfg_data (fit policy)
//
//  A load is written to the table directly, with no scan.
//  An allocation scans every loaded block of the table through its single
//  read port.
//  One transaction is in work at a time; the next is accepted while the
//  result waits in the output register.
//  Reset empties the table and sets the policy to first fit.
// ----------------------------------------------------------------------------
module fit_policy_partition_allocator
    import fpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode,
    input  logic [15:0]         i_size,
    input  logic                i_cfg_we,
    input  logic [POLICY_W-1:0] i_cfg_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_block_index,
    output logic [REM_W-1:0]    o_remaining
);

    logic [POLICY_W-1:0] r_policy;
    logic                r_out_vld;
    t_result             r_out;
    logic                ctrl_busy;
    logic                res_vld;
    t_result             res;
    logic                res_take;

    assign res_take = res_vld && (!r_out_vld || !i_stall);

    fpa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_busy     (ctrl_busy),
        .i_mode     (i_mode),
        .i_size     (i_size),
        .i_policy   (r_policy),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_take (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_FIRST;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_data;
            end
            if (res_take) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_stall       = ctrl_busy;
    assign o_valid       = r_out_vld;
    assign o_status      = r_out.status;
    assign o_block_index = r_out.block_index;
    assign o_remaining   = r_out.remaining;

endmodule

// ===== rtl/fpa_checker.sv =====
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks for the fit-policy partition allocator.
// ----------------------------------------------------------------------------
module fpa_checker
    import fpa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [INDEX_W-1:0]  o_block_index,
    input logic [REM_W-1:0]    o_remaining
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NOFIT || o_status == ST_FULL)
        |-> (o_block_index == '0) && (o_remaining == '0))
        else $error("failed transaction carries nonzero index or remaining");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled while a transaction is in work");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
        && $stable(o_block_index) && $stable(o_remaining))
        else $error("stalled result changed");

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (.*);

// ===== tb/fit_policy_partition_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator_tb
// Loads free blocks and issues allocation requests under every fit policy.
// A scoreboard keeps its own copy of the block table, predicts the status,
// block index and remaining size of each transaction, and checks the results
// in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
package fpa_tb_pkg;
    import fpa_pkg::*;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;
    localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

    class alloc_scoreboard;
        logic [REM_W-1:0]    free_size [MAX_BLOCKS_DEF];
        logic [4:0]          used_blocks;
        logic [POLICY_W-1:0] policy;
        t_result             awaited [$];
        int                  errors;

        function new();
            used_blocks = '0;
            policy      = POL_FIRST;
            errors      = 0;
            foreach (free_size[i]) free_size[i] = '0;
        endfunction

        function void set_policy(logic [POLICY_W-1:0] p);
            policy = p;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(logic mode, logic [15:0] size);
            t_result r;
            logic    found;
            int      pick;
            r     = '0;
            found = 1'b0;
            pick  = 0;
            if (mode == MODE_LOAD) begin
                if (used_blocks >= MAX_BLOCKS_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    free_size[used_blocks] = size;
                    r.status      = ST_LOADED;
                    r.block_index = used_blocks[INDEX_W-1:0];
                    r.remaining   = size;
                    used_blocks++;
                end
            end else begin
                for (int i = 0; i < used_blocks; i++) begin
                    if (size <= free_size[i]) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = i;
                        end else if (policy == POL_BEST && free_size[i] < free_size[pick]) begin
                            pick = i;
                        end else if (policy == POL_WORST && free_size[i] > free_size[pick]) begin
                            pick = i;
                        end
                    end
                end
                if (!found) begin
                    r.status = ST_NOFIT;
                end else begin
                    free_size[pick] = free_size[pick] - size;
                    r.status        = ST_ALLOC;
                    r.block_index   = pick[INDEX_W-1:0];
                    r.remaining     = free_size[pick];
                end
            end
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_response(logic [STATUS_W-1:0] status,
                                     logic [INDEX_W-1:0] block_index,
                                     logic [REM_W-1:0] remaining);
            t_result exp;
            if (awaited.size() == 0) begin
                $error("result with no transaction pending: status %0d index %0d remaining %0d",
                       status, block_index, remaining);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, status);
                errors++;
            end
            if (block_index !== exp.block_index) begin
                $error("block_index: expected %0d, actual %0d", exp.block_index, block_index);
                errors++;
            end
            if (remaining !== exp.remaining) begin
                $error("remaining: expected %0d, actual %0d", exp.remaining, remaining);
                errors++;
            end
        endfunction
    endclass
endpackage

module fit_policy_partition_allocator_tb;
    import fpa_pkg::*;
    import fpa_tb_pkg::*;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                i_mode     = 1'b0;
    logic [15:0]         i_size     = '0;
    logic                i_cfg_we   = 1'b0;
    logic [POLICY_W-1:0] i_cfg_data = '0;
    logic                i_stall    = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_block_index;
    logic [REM_W-1:0]    o_remaining;

    bit                  quiet = 1'b0;
    alloc_scoreboard     sb = new();

    logic [POLICY_W-1:0] phase_policy [8] = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE,
                                              POL_BEST, POL_WORST, POL_FIRST, POL_BEST};

    fit_policy_partition_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_size        (i_size),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_block_index (o_block_index),
        .o_remaining   (o_remaining)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("fit_policy_partition_allocator: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            sb.check_response(o_status, o_block_index, o_remaining);
        end
        i_stall <= i_rst_n && !quiet && ($urandom_range(0, 99) < 9);
    end

    task automatic send_item(input logic mode, input logic [15:0] size);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 9) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_size  <= size;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(mode, size);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_policy(input logic [POLICY_W-1:0] p);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        sb.set_policy(p);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [16:0] largest_free();
        logic [16:0] top;
        top = '0;
        for (int i = 0; i < sb.used_blocks; i++) begin
            if (sb.free_size[i] > top) top = 17'(sb.free_size[i]);
        end
        return top;
    endfunction

    function automatic int low_block();
        int cand [$];
        for (int i = 0; i < sb.used_blocks; i++) begin
            if (sb.free_size[i] <= 2048) cand.insert(cand.size(), i);
        end
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic random_item();
        int          roll;
        int          pick;
        logic [16:0] top;
        logic [15:0] size;
        roll = $urandom_range(0, 99);
        size = 16'($urandom_range(0, 65535) >> $urandom_range(6, 15));
        if (roll < 10) begin
            send_item(MODE_LOAD, 16'($urandom_range(0, 65535)));
            return;
        end
        if (roll < 15) begin
            size = '0;
        end else if (roll < 19) begin
            pick = low_block();
            if (pick >= 0) size = sb.free_size[pick];
        end else if (roll < 25) begin
            top = largest_free() + 17'd1;
            size = top[16] ? 16'($urandom_range(0, 65535)) : top[15:0];
        end else if (roll < 28) begin
            size = 16'($urandom_range(0, 65535));
        end
        send_item(MODE_ALLOC, size);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_policy(POL_FIRST);

        // empty table, then a small set of blocks with ties
        send_item(MODE_ALLOC, 16'd0);
        send_item(MODE_ALLOC, 16'hFFFF);
        send_item(MODE_LOAD, 16'd0);
        send_item(MODE_LOAD, 16'hFFFF);
        send_item(MODE_LOAD, 16'd100);
        send_item(MODE_LOAD, 16'd300);
        send_item(MODE_LOAD, 16'd100);
        send_item(MODE_LOAD, 16'd40);
        send_item(MODE_ALLOC, 16'd0);
        send_item(MODE_ALLOC, 16'd1);
        send_item(MODE_ALLOC, 16'hFFFF);

        drain();
        write_policy(POL_BEST);
        send_item(MODE_ALLOC, 16'd100);
        send_item(MODE_ALLOC, 16'd40);

        drain();
        write_policy(POL_WORST);
        send_item(MODE_ALLOC, 16'd10);

        drain();
        write_policy(POL_SPARE);
        send_item(MODE_ALLOC, 16'd5);

        // fill the table, then overflow it
        send_item(MODE_LOAD, 16'hFFFF);
        send_item(MODE_LOAD, 16'h8000);
        send_item(MODE_LOAD, 16'h7FFF);
        send_item(MODE_LOAD, 16'hAAAA);
        send_item(MODE_LOAD, 16'h5555);
        for (int n = 0; n < 5; n++) send_item(MODE_LOAD, 16'($urandom_range(1024, 65535)));
        send_item(MODE_LOAD, 16'h1234);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_policy(phase_policy[ph]);
            quiet = (ph == 4);
            for (int n = 0; n < 135; n++) begin
                if (ph == 2 && n == 60) drain();
                random_item();
            end
        end
        quiet = 1'b0;

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("fit_policy_partition_allocator: match");
        end else begin
            $display("fit_policy_partition_allocator: mismatch");
        end
        $finish;
    end

endmodule
